// ===== rtl/core/c3f_pkg.sv =====
// Shared types, register codes and size constants for the 3x3 image filter.
`default_nettype none
package c3f_pkg;

    localparam int C3F_MAX_WIDTH  = 1024;
    localparam int C3F_MAX_HEIGHT = 1024;
    localparam int C3F_FRAC_BITS  = 8;

    localparam int PIX_W    = 8;
    localparam int COEF_W   = 16;
    localparam int KROW_W   = 48;
    localparam int SIZE_W   = 11;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd4;

    localparam logic [KROW_W-1:0] KERNEL_MID_RESET = 48'h0000_0100_0000;
    localparam logic [SIZE_W-1:0] SIZE_RESET       = 11'd1024;

    // Input item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pixel_in;
    } c3f_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             end_of_frame;
    } c3f_out_t;

    // Per-item control from front to back; index 0 = top/left, 2 = bottom/right
    typedef struct packed {
        logic       emit;
        logic       last;
        logic [2:0] row_ok;
        logic [2:0] col_ok;
    } c3f_ctl_t;

    typedef struct packed {
        logic [KROW_W-1:0] top;
        logic [KROW_W-1:0] mid;
        logic [KROW_W-1:0] bot;
    } c3f_kernel_t;

endpackage
`default_nettype wire

// ===== rtl/core/c3f_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module c3f_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/c3f_queue.sv =====
// Short FIFO between the classifying front and the filtering back.
`default_nettype none
module c3f_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      head_data,
    output logic                  empty
);
    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]      count_reg;

    assign full      = (count_reg == (PW+1)'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_data = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/c3f_front.sv =====
// Front end: configuration registers, frame counters and item classification.
`default_nettype none
module c3f_front
    import c3f_pkg::*;
#(
    parameter int MAX_WIDTH  = C3F_MAX_WIDTH,
    parameter int MAX_HEIGHT = C3F_MAX_HEIGHT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [KROW_W-1:0]             cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire c3f_in_t                       s_data,
    input  wire logic                          q_full,
    output logic                               q_push,
    output c3f_ctl_t                           q_ctl,
    output logic [PIX_W-1:0]                   q_pix,
    output logic [$clog2(MAX_WIDTH)-1:0]       q_col,
    output c3f_kernel_t                        kernel
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 3);
    localparam int WD = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int HD = (RW > SIZE_W) ? RW : SIZE_W;

    logic [KROW_W-1:0] ktop_reg, kmid_reg, kbot_reg;
    logic [SIZE_W-1:0] width_reg, height_reg;
    logic [CW-1:0]     icol_reg, icol_next, ocol_reg, ocol_next;
    logic [RW-1:0]     irow_reg, irow_next, orow_reg, orow_next;

    logic [CW-1:0] w_eff;
    logic [RW-1:0] h_eff;
    logic          in_done, drop, take, emit, last;
    logic [CW-1:0] icol_inc, ocol_inc;

    assign kernel = '{top: ktop_reg, mid: kmid_reg, bot: kbot_reg};

    // Clamp the frame size into 1..MAX
    always_comb begin
        if (width_reg == '0) begin
            w_eff = CW'(1);
        end else if (WD'(width_reg) > WD'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = RW'(1);
        end else if (HD'(height_reg) > HD'(MAX_HEIGHT)) begin
            h_eff = RW'(MAX_HEIGHT);
        end else begin
            h_eff = RW'(height_reg);
        end
    end

    // Classify the offered item
    always_comb begin
        in_done = (irow_reg >= h_eff);
        drop    = (s_data.kind == KIND_FLUSH) && !in_done;
        s_ready = !q_full;
        take    = s_valid && s_ready;
        q_push  = take && !drop;
        emit    = ((irow_reg >= RW'(2)) || (irow_reg == RW'(1) && icol_reg != '0))
                  && (orow_reg < h_eff);
        last    = emit && (orow_reg == h_eff - 1'b1) && (ocol_reg == w_eff - 1'b1);

        q_pix          = in_done ? '0 : s_data.pixel_in;
        q_col          = icol_reg[AW-1:0];
        q_ctl.emit     = emit;
        q_ctl.last     = last;
        q_ctl.row_ok   = {orow_reg != h_eff - 1'b1, 1'b1, orow_reg != '0};
        q_ctl.col_ok   = {ocol_reg != w_eff - 1'b1, 1'b1, ocol_reg != '0};
    end

    // Advance the input and output position counters
    always_comb begin
        icol_next = icol_reg;
        irow_next = irow_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        icol_inc  = icol_reg + 1'b1;
        ocol_inc  = ocol_reg + 1'b1;
        if (cfg_wr_en && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT)) begin
            icol_next = '0;
            irow_next = '0;
            ocol_next = '0;
            orow_next = '0;
        end else if (q_push) begin
            if (icol_inc >= w_eff) begin
                icol_next = '0;
                irow_next = irow_reg + 1'b1;
            end else begin
                icol_next = icol_inc;
            end
            if (emit) begin
                if (ocol_inc >= w_eff) begin
                    ocol_next = '0;
                    orow_next = orow_reg + 1'b1;
                end else begin
                    ocol_next = ocol_inc;
                end
            end
            if (last) begin
                icol_next = '0;
                irow_next = '0;
                ocol_next = '0;
                orow_next = '0;
            end
        end
    end

    // Hold registers and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ktop_reg   <= '0;
            kmid_reg   <= KERNEL_MID_RESET;
            kbot_reg   <= '0;
            width_reg  <= SIZE_RESET;
            height_reg <= SIZE_RESET;
            icol_reg   <= '0;
            irow_reg   <= '0;
            ocol_reg   <= '0;
            orow_reg   <= '0;
        end else begin
            icol_reg <= icol_next;
            irow_reg <= irow_next;
            ocol_reg <= ocol_next;
            orow_reg <= orow_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_KERNEL_TOP: ktop_reg   <= cfg_wr_data;
                    REG_KERNEL_MID: kmid_reg   <= cfg_wr_data;
                    REG_KERNEL_BOT: kbot_reg   <= cfg_wr_data;
                    REG_WIDTH:      width_reg  <= cfg_wr_data[SIZE_W-1:0];
                    REG_HEIGHT:     height_reg <= cfg_wr_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/c3f_back.sv =====
// Back end: line store, 3x3 window, products, sum and clamp, output register.
`default_nettype none
module c3f_back
    import c3f_pkg::*;
#(
    parameter int MAX_WIDTH       = C3F_MAX_WIDTH,
    parameter int COEFF_FRAC_BITS = C3F_FRAC_BITS
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    q_empty,
    output logic                         q_pop,
    input  wire c3f_ctl_t                q_ctl,
    input  wire logic [PIX_W-1:0]        q_pix,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] q_col,
    input  wire c3f_kernel_t             kernel,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output c3f_out_t                     m_data
);
    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int PRW  = PIX_W + 1 + COEF_W;
    localparam int SUMW = PRW + 4;

    logic en;

    // Stage B: item whose line-store read is in flight
    logic             b_valid_reg;
    c3f_ctl_t         b_ctl_reg;
    logic [PIX_W-1:0] b_pix_reg;
    logic [AW-1:0]    b_col_reg;
    logic             fwd_reg;
    logic [PIX_W-1:0] fwd_top_reg, fwd_mid_reg;
    logic [2*PIX_W-1:0] rd_data;
    logic [PIX_W-1:0] top, mid;

    logic [PIX_W-1:0] win_reg [9];
    logic [PIX_W-1:0] win_next [9];

    // Stage C: products
    logic                   c_valid_reg, c_last_reg;
    logic signed [PRW-1:0]  c_prod_reg [9];

    logic                   m_valid_reg;
    c3f_out_t               m_data_reg;

    logic signed [SUMW-1:0] sum;
    logic signed [SUMW-1:0] shifted;

    // The whole pipe moves whenever the output register can take a result
    assign en      = !m_valid_reg || m_ready;
    assign q_pop   = en && !q_empty;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Line store: {older, newer} per column
    c3f_ram #(
        .WIDTH(2*PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_line (
        .aclk   (aclk),
        .wr_en  (en && b_valid_reg),
        .wr_addr(b_col_reg),
        .wr_data({mid, b_pix_reg}),
        .rd_en  (q_pop),
        .rd_addr(q_col),
        .rd_data(rd_data)
    );

    // Bypass the write of the item just ahead on the same column
    assign top = fwd_reg ? fwd_top_reg : rd_data[2*PIX_W-1:PIX_W];
    assign mid = fwd_reg ? fwd_mid_reg : rd_data[PIX_W-1:0];

    // Shift the window one column left and insert the new column
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win_next[r*3+0] = win_reg[r*3+1];
            win_next[r*3+1] = win_reg[r*3+2];
        end
        win_next[2] = top;
        win_next[5] = mid;
        win_next[8] = b_pix_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else if (en) begin
            b_valid_reg <= q_pop;
            fwd_reg     <= q_pop && b_valid_reg && (b_col_reg == q_col);
            c_valid_reg <= b_valid_reg && b_ctl_reg.emit;
            m_valid_reg <= c_valid_reg;
            if (b_valid_reg) begin
                for (int i = 0; i < 9; i++) begin
                    win_reg[i] <= win_next[i];
                end
            end
        end
    end

    // Payload of stages B and C
    always_ff @(posedge aclk) begin
        if (en) begin
            b_ctl_reg   <= q_ctl;
            b_pix_reg   <= q_pix;
            b_col_reg   <= q_col;
            fwd_top_reg <= mid;
            fwd_mid_reg <= b_pix_reg;
            c_last_reg  <= b_ctl_reg.last;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    logic [KROW_W-1:0] krow;
                    logic signed [COEF_W-1:0] coef;
                    krow = (r == 0) ? kernel.top : ((r == 1) ? kernel.mid : kernel.bot);
                    coef = $signed(krow[COEF_W*c +: COEF_W]);
                    if (b_ctl_reg.row_ok[r] && b_ctl_reg.col_ok[c]) begin
                        c_prod_reg[r*3+c] <= PRW'($signed({1'b0, win_next[r*3+c]}))
                                             * PRW'(coef);
                    end else begin
                        c_prod_reg[r*3+c] <= '0;
                    end
                end
            end
        end
    end

    // Sum, floor and clamp
    always_comb begin
        sum = '0;
        for (int i = 0; i < 9; i++) begin
            sum = sum + SUMW'(c_prod_reg[i]);
        end
        shifted = sum >>> COEFF_FRAC_BITS;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg.end_of_frame <= c_last_reg;
            if (sum < 0) begin
                m_data_reg.pixel_out <= '0;
            end else if (shifted > SUMW'(255)) begin
                m_data_reg.pixel_out <= '1;
            end else begin
                m_data_reg.pixel_out <= shifted[PIX_W-1:0];
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/conv3x3_clamped_image_filter.sv =====
// Top level of the streaming 3x3 convolution filter with zero padding and clamp.
// Throughput: one item per cycle, sustained, when the result side keeps up.
// The item that completes a window passes the queue, the line-store read, the
// product stage and the sum/clamp output register before its result leaves.
// A result waiting in the output register stalls the back end only; the front
// keeps accepting into its 4-entry queue. Synchronous active-low reset clears
// control state, counters, window and restores register reset values.
`default_nettype none
module conv3x3_clamped_image_filter
    import c3f_pkg::*;
#(
    parameter int MAX_WIDTH       = C3F_MAX_WIDTH,
    parameter int MAX_HEIGHT      = C3F_MAX_HEIGHT,
    parameter int COEFF_FRAC_BITS = C3F_FRAC_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [KROW_W-1:0]    cfg_wr_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire c3f_in_t              s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output c3f_out_t                  m_data
);
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int CTW = $bits(c3f_ctl_t);
    localparam int QW  = CTW + PIX_W + AW;

    logic             q_push, q_full, q_pop, q_empty;
    c3f_ctl_t         f_ctl, b_ctl;
    logic [PIX_W-1:0] f_pix, b_pix;
    logic [AW-1:0]    f_col, b_col;
    logic [QW-1:0]    q_head;
    c3f_kernel_t      kernel;

    c3f_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_ctl      (f_ctl),
        .q_pix      (f_pix),
        .q_col      (f_col),
        .kernel     (kernel)
    );

    c3f_queue #(
        .WIDTH(QW),
        .DEPTH(4)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data({f_ctl, f_pix, f_col}),
        .full     (q_full),
        .pop      (q_pop),
        .head_data(q_head),
        .empty    (q_empty)
    );

    assign b_ctl = c3f_ctl_t'(q_head[QW-1 -: CTW]);
    assign b_pix = q_head[AW +: PIX_W];
    assign b_col = q_head[AW-1:0];

    c3f_back #(
        .MAX_WIDTH      (MAX_WIDTH),
        .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
    ) u_back (
        .aclk   (aclk),
        .aresetn(aresetn),
        .q_empty(q_empty),
        .q_pop  (q_pop),
        .q_ctl  (b_ctl),
        .q_pix  (b_pix),
        .q_col  (b_col),
        .kernel (kernel),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );
endmodule
`default_nettype wire

// ===== rtl/core/c3f_checker.sv =====
// Port-level checker for the 3x3 image filter and its bind to the top level.
`default_nettype none
module c3f_checker
    import c3f_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_ready,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire c3f_out_t m_data
);
    // A stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result payload changed while stalled");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered right after reset");

    // Reset empties the queue so input is taken at once
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");
endmodule

bind conv3x3_clamped_image_filter c3f_checker u_c3f_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
`default_nettype wire
